FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros
// concurrent assertion shorthands for the console checker
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define TCW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("console assertion failed");

// next-cycle implication, disabled while in reset
`define TCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("console assertion failed");

`endif

FILE: rtl/tcw_pkg.sv
// ---------------------------------------------------------------------------
// tcw_pkg
// shared constants and types of the text console character writer
// ---------------------------------------------------------------------------
package tcw_pkg;

    // screen geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;

    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);

    // port field widths
    localparam int MODE_W      = 1;
    localparam int CHAR_W      = 8;
    localparam int INDEX_W     = 11;
    localparam int START_W     = 11;
    localparam int ATTR_W      = 8;
    localparam int ROW_OUT_W   = 5;
    localparam int COL_OUT_W   = 7;
    localparam int POS_OUT_W   = 11;
    localparam int CELL_W      = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 11;

    // character codes
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

    localparam logic [CELL_W-1:0] BLANK_CELL = {RESET_ATTR, CHAR_SPACE};

    localparam logic [MODE_W-1:0] MODE_WRITE = 1'b0;
    localparam logic [MODE_W-1:0] MODE_READ  = 1'b1;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_START_POSITION = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_TEXT_ATTRIBUTE = 1'b1;

    // cursor landmarks
    localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'(CELL_COUNT - COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_CELL     = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] COL_STEP      = ADDR_W'(COLUMNS);
    localparam logic [ROW_W-1:0]  LAST_ROW      = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  LAST_COL      = COL_W'(COLUMNS - 1);

    typedef enum logic [1:0] {
        OP_READ,
        OP_CR,
        OP_LF,
        OP_CHAR
    } op_t;

    // classified command between front and back
    typedef struct packed {
        op_t               op;
        logic [CHAR_W-1:0] char_code;
        logic [ADDR_W-1:0] addr;
        logic              in_range;
    } cmd_t;

    // command queue status
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

FILE: rtl/tcw_if.sv
// ---------------------------------------------------------------------------
// tcw_if
// valid/ready channels of the text console character writer
// ---------------------------------------------------------------------------
interface tcw_item_if import tcw_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [MODE_W-1:0]    mode;
    logic [CHAR_W-1:0]    char_code;
    logic [INDEX_W-1:0]   cell_index;

    modport source (output valid, output mode, output char_code, output cell_index,
                    input ready);
    modport sink   (input valid, input mode, input char_code, input cell_index,
                    output ready);
endinterface

interface tcw_result_if import tcw_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [ROW_OUT_W-1:0] cursor_row;
    logic [COL_OUT_W-1:0] cursor_col;
    logic [POS_OUT_W-1:0] cursor_position;
    logic                 scrolled;
    logic [CELL_W-1:0]    cell_data;

    modport source (output valid, output cursor_row, output cursor_col,
                    output cursor_position, output scrolled, output cell_data,
                    input ready);
    modport sink   (input valid, input cursor_row, input cursor_col,
                    input cursor_position, input scrolled, input cell_data,
                    output ready);
endinterface

interface tcw_cfg_if import tcw_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/text_console_char_writer.sv
// ---------------------------------------------------------------------------
// text_console_char_writer
// text-mode console: character writes, cursor tracking, scroll and cell readback
// ---------------------------------------------------------------------------
// After reset the block blanks the screen memory and takes no input word in that
// time; config writes are taken at any time. Each input word gives exactly one
// result word. A CR, LF or ordinary character passes the back-end states idle,
// execute and done and then the result register; a cell read also passes a
// read-wait state, for the registered read port of the screen memory. The first
// CR, LF or character after reset also walks the start position down to row and
// column, one row per cycle. A scroll copies the screen one cell per cycle
// through the one memory write port and blanks the last row. A two-entry command
// queue lets input words keep arriving while the back end is busy or a result
// waits to be taken.
module text_console_char_writer import tcw_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    tcw_item_if.sink     item,
    tcw_result_if.source result,
    tcw_cfg_if.sink      cfg
);

    // front to queue
    logic    push;
    cmd_t    push_cmd;
    // queue to back
    logic    pop;
    cmd_t    pop_cmd;
    q_stat_t q_stat;
    // back end blanking the screen after reset
    logic    clear_busy;

    // accept and classify words
    tcw_front u_front
    (
        .item       (item),
        .q_stat     (q_stat),
        .clear_busy (clear_busy),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    // decouple front from back
    tcw_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .stat     (q_stat)
    );

    // cursor, screen memory, scroll engine and result register
    tcw_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_stat     (q_stat),
        .pop_cmd    (pop_cmd),
        .pop        (pop),
        .clear_busy (clear_busy),
        .result     (result),
        .cfg        (cfg)
    );

endmodule

FILE: rtl/tcw_front.sv
// ---------------------------------------------------------------------------
// tcw_front
// accepts input words and classifies them into queue commands
// ---------------------------------------------------------------------------
module tcw_front import tcw_pkg::*;
(
    tcw_item_if.sink item,
    input  q_stat_t  q_stat,
    input  logic     clear_busy,
    output logic     push,
    output cmd_t     push_cmd
);

    logic in_range;

    // hold off while the screen is being cleared after reset
    assign item.ready = !q_stat.full && !clear_busy;
    assign push       = item.valid && item.ready;

    assign in_range = (32'(item.cell_index) < CELL_COUNT);

    always_comb
    begin
        push_cmd.char_code = item.char_code;
        push_cmd.in_range  = in_range;
        push_cmd.addr      = in_range ? ADDR_W'(item.cell_index) : '0;
        if (item.mode == MODE_READ)
        begin
            push_cmd.op = OP_READ;
        end
        else
        begin
            unique case (item.char_code)
                CHAR_CR: push_cmd.op = OP_CR;
                CHAR_LF: push_cmd.op = OP_LF;
                default: push_cmd.op = OP_CHAR;
            endcase
        end
    end

endmodule

FILE: rtl/tcw_queue.sv
// ---------------------------------------------------------------------------
// tcw_queue
// two-entry command queue between front and back
// ---------------------------------------------------------------------------
module tcw_queue import tcw_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  cmd_t    push_cmd,
    input  logic    pop,
    output cmd_t    pop_cmd,
    output q_stat_t stat
);

    cmd_t       entries_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push_ok;
    logic       pop_ok;

    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);
    assign push_ok    = push && !stat.full;
    assign pop_ok     = pop && !stat.empty;
    assign pop_cmd    = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push_ok ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop_ok ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push_ok) - 2'(pop_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: rtl/tcw_back.sv
// ---------------------------------------------------------------------------
// tcw_back
// executes commands: cursor, screen memory, scroll, clear and result register
// ---------------------------------------------------------------------------
module tcw_back import tcw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  q_stat_t  q_stat,
    input  cmd_t     pop_cmd,
    output logic     pop,
    output logic     clear_busy,
    tcw_result_if.source result,
    tcw_cfg_if.sink  cfg
);

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_EXEC   = 4'd2;
    localparam logic [3:0] ST_LOAD   = 4'd3;
    localparam logic [3:0] ST_RDWAIT = 4'd4;
    localparam logic [3:0] ST_SCROLL = 4'd5;
    localparam logic [3:0] ST_DRAIN  = 4'd6;
    localparam logic [3:0] ST_FILL   = 4'd7;
    localparam logic [3:0] ST_DONE   = 4'd8;

    logic [CELL_W-1:0]    mem [CELL_COUNT];
    logic [CELL_W-1:0]    rdata_reg;
    logic                 we;
    logic [ADDR_W-1:0]    waddr;
    logic [CELL_W-1:0]    wdata;
    logic [ADDR_W-1:0]    rd_addr;

    logic [3:0]           state_reg, state_next;
    cmd_t                 cur_reg, cur_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [ADDR_W-1:0]    pos_reg, pos_next;
    logic                 loaded_reg, loaded_next;
    logic [ADDR_W-1:0]    rem_reg, rem_next;
    logic [ADDR_W-1:0]    src_reg, src_next;
    logic [ADDR_W-1:0]    dst_reg, dst_next;
    logic                 pend_reg, pend_next;
    logic                 scr_flag_reg, scr_flag_next;
    logic [CELL_W-1:0]    data_reg, data_next;
    logic [START_W-1:0]   start_reg, start_next;
    logic [ATTR_W-1:0]    attr_reg, attr_next;
    logic                 out_valid_reg, out_valid_next;
    logic [ROW_OUT_W-1:0] out_row_reg, out_row_next;
    logic [COL_OUT_W-1:0] out_col_reg, out_col_next;
    logic [POS_OUT_W-1:0] out_pos_reg, out_pos_next;
    logic                 out_scr_reg, out_scr_next;
    logic [CELL_W-1:0]    out_data_reg, out_data_next;

    logic [ADDR_W-1:0]    start_clamped;
    logic                 last_row;
    logic                 last_col;

    assign cfg.ready       = 1'b1;
    assign clear_busy      = (state_reg == ST_CLEAR);
    assign result.valid    = out_valid_reg;
    assign result.cursor_row      = out_row_reg;
    assign result.cursor_col      = out_col_reg;
    assign result.cursor_position = out_pos_reg;
    assign result.scrolled        = out_scr_reg;
    assign result.cell_data       = out_data_reg;

    assign start_clamped = (32'(start_reg) < CELL_COUNT) ? ADDR_W'(start_reg) : '0;
    assign last_row      = (row_reg == LAST_ROW);
    assign last_col      = (col_reg == LAST_COL);

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        pos_next       = pos_reg;
        loaded_next    = loaded_reg;
        rem_next       = rem_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        pend_next      = pend_reg;
        scr_flag_next  = scr_flag_reg;
        data_next      = data_reg;
        start_next     = start_reg;
        attr_next      = attr_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_pos_next   = out_pos_reg;
        out_scr_next   = out_scr_reg;
        out_data_next  = out_data_reg;
        pop            = 1'b0;
        we             = 1'b0;
        waddr          = dst_reg;
        wdata          = BLANK_CELL;
        rd_addr        = cur_reg.addr;

        if (cfg.valid)
        begin
            if (cfg.index == REG_START_POSITION)
            begin
                start_next = cfg.data[START_W-1:0];
            end
            else
            begin
                attr_next = cfg.data[ATTR_W-1:0];
            end
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                we       = 1'b1;
                dst_next = dst_reg + ADDR_W'(1);
                if (dst_reg == LAST_CELL)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop           = 1'b1;
                    cur_next      = pop_cmd;
                    scr_flag_next = 1'b0;
                    data_next     = '0;
                    state_next    = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                if (cur_reg.op != OP_READ && !loaded_reg)
                begin
                    rem_next   = start_clamped;
                    row_next   = '0;
                    state_next = ST_LOAD;
                end
                else
                begin
                    state_next = ST_DONE;
                    case (cur_reg.op)
                        OP_READ:
                        begin
                            state_next = ST_RDWAIT;
                        end
                        OP_CR:
                        begin
                            col_next = '0;
                            pos_next = pos_reg - ADDR_W'(col_reg);
                        end
                        OP_LF:
                        begin
                            col_next = '0;
                            if (!last_row)
                            begin
                                row_next = row_reg + ROW_W'(1);
                                pos_next = pos_reg - ADDR_W'(col_reg) + COL_STEP;
                            end
                        end
                        default:
                        begin
                            we    = 1'b1;
                            waddr = pos_reg;
                            wdata = {attr_reg, cur_reg.char_code};
                            if (last_col)
                            begin
                                col_next = '0;
                                if (!last_row)
                                begin
                                    row_next = row_reg + ROW_W'(1);
                                    pos_next = pos_reg + ADDR_W'(1);
                                end
                            end
                            else
                            begin
                                col_next = col_reg + COL_W'(1);
                                pos_next = pos_reg + ADDR_W'(1);
                            end
                        end
                    endcase
                    // stepping below the last row scrolls the screen
                    if (last_row && (cur_reg.op == OP_LF || (cur_reg.op == OP_CHAR && last_col)))
                    begin
                        pos_next      = LAST_ROW_BASE;
                        scr_flag_next = 1'b1;
                        src_next      = COL_STEP;
                        dst_next      = '0;
                        pend_next     = 1'b0;
                        state_next    = ST_SCROLL;
                    end
                end
            end

            ST_LOAD:
            begin
                // one column-width subtraction per cycle
                if (rem_reg >= COL_STEP)
                begin
                    rem_next = rem_reg - COL_STEP;
                    row_next = row_reg + ROW_W'(1);
                end
                else
                begin
                    col_next    = COL_W'(rem_reg);
                    pos_next    = start_clamped;
                    loaded_next = 1'b1;
                    state_next  = ST_EXEC;
                end
            end

            ST_RDWAIT:
            begin
                data_next  = cur_reg.in_range ? rdata_reg : '0;
                state_next = ST_DONE;
            end

            ST_SCROLL:
            begin
                rd_addr   = src_reg;
                src_next  = src_reg + ADDR_W'(1);
                pend_next = 1'b1;
                if (pend_reg)
                begin
                    we       = 1'b1;
                    wdata    = rdata_reg;
                    dst_next = dst_reg + ADDR_W'(1);
                end
                if (src_reg == LAST_CELL)
                begin
                    state_next = ST_DRAIN;
                end
            end

            ST_DRAIN:
            begin
                we         = 1'b1;
                wdata      = rdata_reg;
                dst_next   = dst_reg + ADDR_W'(1);
                pend_next  = 1'b0;
                state_next = ST_FILL;
            end

            ST_FILL:
            begin
                we       = 1'b1;
                wdata    = {attr_reg, CHAR_SPACE};
                dst_next = dst_reg + ADDR_W'(1);
                if (dst_reg == LAST_CELL)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_row_next   = ROW_OUT_W'(row_reg);
                    out_col_next   = COL_OUT_W'(col_reg);
                    out_pos_next   = POS_OUT_W'(pos_reg);
                    out_scr_next   = scr_flag_reg;
                    out_data_next  = data_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            row_reg       <= '0;
            col_reg       <= '0;
            pos_reg       <= '0;
            loaded_reg    <= 1'b0;
            dst_reg       <= '0;
            pend_reg      <= 1'b0;
            start_reg     <= '0;
            attr_reg      <= RESET_ATTR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            pos_reg       <= pos_next;
            loaded_reg    <= loaded_next;
            dst_reg       <= dst_next;
            pend_reg      <= pend_next;
            start_reg     <= start_next;
            attr_reg      <= attr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        rem_reg      <= rem_next;
        src_reg      <= src_next;
        scr_flag_reg <= scr_flag_next;
        data_reg     <= data_next;
        out_row_reg  <= out_row_next;
        out_col_reg  <= out_col_next;
        out_pos_reg  <= out_pos_next;
        out_scr_reg  <= out_scr_next;
        out_data_reg <= out_data_next;
    end

    // screen memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[rd_addr];
    end

endmodule

FILE: rtl/tcw_checker.sv
// ---------------------------------------------------------------------------
// tcw_checker
// port-level checks of the text console character writer
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tcw_checker import tcw_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 result_valid,
    input logic                 result_ready,
    input logic [ROW_OUT_W-1:0] cursor_row,
    input logic [COL_OUT_W-1:0] cursor_col,
    input logic [POS_OUT_W-1:0] cursor_position,
    input logic                 scrolled,
    input logic [CELL_W-1:0]    cell_data
);

    // a stalled result word stays offered
    `TCW_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid)

    // linear position agrees with row and column
    `TCW_ASSERT_IMPL(a_pos_match, clk, rst_n, result_valid, POS_OUT_W'(32'(cursor_row) * COLUMNS + 32'(cursor_col)) == cursor_position)

    // a scroll leaves the cursor at the start of the last row
    `TCW_ASSERT_IMPL(a_scroll_cursor, clk, rst_n, result_valid && scrolled, (cursor_row == ROW_OUT_W'(ROWS - 1)) && (cursor_col == '0))

    // a scroll only comes from a write, which returns no cell data
    `TCW_ASSERT_IMPL(a_scroll_data, clk, rst_n, result_valid && scrolled, cell_data == '0)

endmodule

bind text_console_char_writer tcw_checker u_tcw_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .result_valid    (result.valid),
    .result_ready    (result.ready),
    .cursor_row      (result.cursor_row),
    .cursor_col      (result.cursor_col),
    .cursor_position (result.cursor_position),
    .scrolled        (result.scrolled),
    .cell_data       (result.cell_data)
);

FILE: bench/text_console_char_writer_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// text_console_char_writer_checker
// follows the console channels, keeps its own screen and cursor, and
// compares each report word with the predicted one
// ---------------------------------------------------------------------------
module text_console_char_writer_checker import tcw_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    tcw_item_if   item,
    tcw_result_if result,
    tcw_cfg_if    cfg,
    input  logic  drain_done,
    output int    fail_count
);

    typedef struct packed {
        logic [ROW_OUT_W-1:0] row;
        logic [COL_OUT_W-1:0] col;
        logic [POS_OUT_W-1:0] pos;
        logic                 scrolled;
        logic [CELL_W-1:0]    cell_word;
    } console_report_t;

    logic [CELL_W-1:0]  screen [CELL_COUNT];
    int unsigned        cur_row;
    int unsigned        cur_col;
    bit                 cursor_loaded;
    logic [START_W-1:0] start_reg;
    logic [ATTR_W-1:0]  attr_reg;
    console_report_t    awaited_reports [$];
    int                 mismatches = 0;
    bit                 leftover_checked = 0;

    assign fail_count = mismatches;

    function automatic console_report_t predict_console_word(logic [MODE_W-1:0] mode,
                                                             logic [CHAR_W-1:0] ch,
                                                             logic [INDEX_W-1:0] idx);
        console_report_t rep;
        int unsigned     pos;
        rep = '0;
        if (mode == MODE_READ)
        begin
            if (idx < CELL_COUNT)
                rep.cell_word = screen[idx];
        end
        else
        begin
            if (!cursor_loaded)
            begin
                pos = start_reg;
                if (pos >= CELL_COUNT)
                    pos = 0;
                cur_row       = pos / COLUMNS;
                cur_col       = pos % COLUMNS;
                cursor_loaded = 1'b1;
            end
            if (ch == CHAR_CR)
                cur_col = 0;
            else if (ch == CHAR_LF)
            begin
                cur_col = 0;
                cur_row++;
            end
            else
            begin
                screen[cur_row * COLUMNS + cur_col] = {attr_reg, ch};
                cur_col++;
                if (cur_col >= COLUMNS)
                begin
                    cur_col = 0;
                    cur_row++;
                end
            end
            if (cur_row >= ROWS)
            begin
                // move every row up, bottom row blank in the current attribute
                for (int i = 0; i + COLUMNS < CELL_COUNT; i++)
                    screen[i] = screen[i + COLUMNS];
                for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
                    screen[i] = {attr_reg, CHAR_SPACE};
                cur_row      = ROWS - 1;
                rep.scrolled = 1'b1;
            end
        end
        pos = cur_row * COLUMNS + cur_col;
        rep.row = ROW_OUT_W'(cur_row);
        rep.col = COL_OUT_W'(cur_col);
        rep.pos = POS_OUT_W'(pos);
        return rep;
    endfunction

    function automatic void check_field(string field, longint unsigned want,
                                        longint unsigned got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        console_report_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < CELL_COUNT; i++)
                screen[i] = BLANK_CELL;
            cur_row       = 0;
            cur_col       = 0;
            cursor_loaded = 1'b0;
            start_reg     = '0;
            attr_reg      = RESET_ATTR;
            awaited_reports.delete();
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (awaited_reports.size() == 0)
                begin
                    $display("%0t ns: report word with none outstanding, expected none, actual row %0d col %0d data %0d",
                             $time, result.cursor_row, result.cursor_col, result.cell_data);
                    mismatches++;
                end
                else
                begin
                    want = awaited_reports.pop_front();
                    check_field("cursor_row", want.row, result.cursor_row);
                    check_field("cursor_col", want.col, result.cursor_col);
                    check_field("cursor_position", want.pos, result.cursor_position);
                    check_field("scrolled", want.scrolled, result.scrolled);
                    check_field("cell_data", want.cell_word, result.cell_data);
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_START_POSITION: start_reg = cfg.data[START_W-1:0];
                    REG_TEXT_ATTRIBUTE: attr_reg  = cfg.data[ATTR_W-1:0];
                    default: ;
                endcase
            end
            if (item.valid && item.ready)
                awaited_reports.push_back(predict_console_word(item.mode, item.char_code,
                                                               item.cell_index));
            if (drain_done && !leftover_checked)
            begin
                leftover_checked = 1'b1;
                if (awaited_reports.size() != 0)
                begin
                    want = awaited_reports[0];
                    $display("%0t ns: %0d report words missing, expected row %0d col %0d, actual none",
                             $time, awaited_reports.size(), want.row, want.col);
                    mismatches++;
                end
            end
        end
    end

endmodule

FILE: bench/text_console_char_writer_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// text_console_char_writer_test
// drives characters, control codes and cell reads into the console under
// several attribute and start position settings, with random idling on both
// sides; a checker beside the block predicts and compares every report word
// ---------------------------------------------------------------------------
module text_console_char_writer_test;
    import tcw_pkg::*;

    localparam int PHASES          = 6;
    localparam int WORDS_PER_PHASE = 256;
    localparam int IDLE_PCT        = 8;
    localparam int HOLD_CYCLES     = 500;
    localparam int HOLD_AT_WORD    = 400;
    localparam int CALM_FIRST      = 700;
    localparam int CALM_LAST       = 1000;

    logic clk;
    logic rst_n;
    logic drain_done;
    logic calm_stretch;
    int   items_sent    = 0;
    int   reports_taken = 0;
    int   fail_count;

    tcw_item_if   item_ch ();
    tcw_result_if result_ch ();
    tcw_cfg_if    cfg_ch ();

    text_console_char_writer u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    text_console_char_writer_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_ch),
        .result     (result_ch),
        .cfg        (cfg_ch),
        .drain_done (drain_done),
        .fail_count (fail_count)
    );

    // clock, 12 ns period
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // window with no idling on either side
    assign calm_stretch = (items_sent >= CALM_FIRST) && (items_sent < CALM_LAST);

    // hard stop, far beyond the slowest run incl. the clearing pass and scrolls
    initial
    begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // count taken report words, used to see when the block is idle
    always @(posedge clk)
    begin
        if (result_ch.valid && result_ch.ready)
            reports_taken <= reports_taken + 1;
    end

    // report side: random stalls, one long hold-off that backs up the input
    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left       = 0;
        hold_done       = 1'b0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && items_sent >= HOLD_AT_WORD)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (calm_stretch)
                result_ch.ready <= 1'b1;
            else
                result_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // offer one word; returns at the falling edge after acceptance, valid still high
    task automatic send_word(logic [MODE_W-1:0] mode, logic [CHAR_W-1:0] ch,
                             logic [INDEX_W-1:0] idx);
        while (!calm_stretch && $urandom_range(0, 99) < IDLE_PCT)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.mode       <= mode;
        item_ch.char_code  <= ch;
        item_ch.cell_index <= idx;
        do
            @(posedge clk);
        while (!item_ch.ready);
        items_sent++;
        @(negedge clk);
    endtask

    // one register write; caller lowers valid after the last one
    task automatic write_register(logic [CFG_INDEX_W-1:0] index,
                                  logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
    endtask

    // stop offering and wait until every report word is back, plus a margin
    task automatic settle();
        item_ch.valid <= 1'b0;
        while (reports_taken != items_sent)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    function automatic logic [INDEX_W-1:0] any_index();
        return INDEX_W'($urandom_range(0, 2 ** INDEX_W - 1));
    endfunction

    initial
    begin
        logic [START_W-1:0] start_pick;
        logic [ATTR_W-1:0]  attr_pick;
        logic [INDEX_W-1:0] idx;
        int                 roll;

        // every input known from time zero
        rst_n              = 1'b0;
        drain_done         = 1'b0;
        item_ch.valid      = 1'b0;
        item_ch.mode       = MODE_WRITE;
        item_ch.char_code  = '0;
        item_ch.cell_index = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = REG_START_POSITION;
        cfg_ch.data        = '0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // start position is only taken once, so the seed picks which case
        case ($urandom_range(0, 3))
            0:       start_pick = START_W'(2 ** START_W - 1);   // out of range, reads as 0
            1:       start_pick = LAST_CELL;                    // first char wraps and scrolls
            2:       start_pick = LAST_ROW_BASE;
            default: start_pick = START_W'($urandom_range(0, 2 ** START_W - 1));
        endcase
        write_register(REG_START_POSITION, start_pick);
        cfg_ch.valid <= 1'b0;

        // directed part, reset attribute still in force
        send_word(MODE_READ, 8'hFF, '0);                     // read before cursor is loaded
        send_word(MODE_READ, CHAR_CR, INDEX_W'(2 ** INDEX_W - 1)); // index past the screen
        send_word(MODE_WRITE, 8'h41, INDEX_W'(2 ** INDEX_W - 1)); // loads the cursor
        send_word(MODE_WRITE, 8'h00, '0);
        send_word(MODE_WRITE, 8'hFF, '0);
        send_word(MODE_WRITE, CHAR_CR, '0);
        send_word(MODE_WRITE, 8'h7E, '0);
        send_word(MODE_WRITE, CHAR_LF, '0);
        send_word(MODE_WRITE, CHAR_LF, '0);
        send_word(MODE_READ, 8'h00, LAST_ROW_BASE);
        send_word(MODE_READ, 8'h00, LAST_CELL);
        send_word(MODE_READ, 8'h00, INDEX_W'(CELL_COUNT));   // first index out of range
        send_word(MODE_WRITE, CHAR_SPACE, '0);
        send_word(MODE_READ, CHAR_LF, INDEX_W'(1));
        send_word(MODE_READ, 8'h00, '0);

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            // extremes first, then random settings
            case (p)
                0:
                begin
                    start_pick = '0;
                    attr_pick  = 8'hFF;
                end
                1:
                begin
                    start_pick = START_W'(2 ** START_W - 1);
                    attr_pick  = 8'h00;
                end
                default:
                begin
                    start_pick = START_W'($urandom_range(0, 2 ** START_W - 1));
                    attr_pick  = ATTR_W'($urandom_range(0, 255));
                end
            endcase
            write_register(REG_START_POSITION, start_pick);
            // upper data bits are junk for the attribute register
            write_register(REG_TEXT_ATTRIBUTE,
                           {(CFG_DATA_W - ATTR_W)'($urandom), attr_pick});
            cfg_ch.valid <= 1'b0;

            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 25)
                begin
                    // cell read, now and then past the screen
                    if ($urandom_range(0, 9) == 0)
                        idx = INDEX_W'($urandom_range(CELL_COUNT, 2 ** INDEX_W - 1));
                    else
                        idx = INDEX_W'($urandom_range(0, CELL_COUNT - 1));
                    send_word(MODE_READ, CHAR_W'($urandom_range(0, 255)), idx);
                end
                else if (roll < 28)
                    send_word(MODE_WRITE, CHAR_LF, any_index());   // kept rare, scrolls are slow
                else if (roll < 33)
                    send_word(MODE_WRITE, CHAR_CR, any_index());
                else
                    send_word(MODE_WRITE, CHAR_W'($urandom_range(0, 255)), any_index());
            end
        end

        settle();
        drain_done <= 1'b1;
        repeat (2) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
